// ===== hw/rtl/pid_with_filtered_derivative_top_assert.svh =====
// assertion macros shared by the pid block modules
`ifndef PID_WITH_FILTERED_DERIVATIVE_TOP_ASSERT_SVH
`define PID_WITH_FILTERED_DERIVATIVE_TOP_ASSERT_SVH

// same-cycle implication
`define PIDFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pidfd same-cycle check failed");

// next-cycle implication
`define PIDFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pidfd next-cycle check failed");

`endif

// ===== hw/rtl/pidfd_pkg.sv =====
// shared types and constants of the pid block
`default_nettype none

package pidfd_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned GAIN_W   = 31;
   localparam int unsigned ALPHA_W  = 17;
   localparam int unsigned CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_ALPHA  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_BAND    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_LIMIT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_CAP    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd7;

   // register reset values
   localparam logic [GAIN_W-1:0]  RST_PROP_GAIN     = 31'd65536;
   localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN    = 31'd0;
   localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN    = 31'd0;
   localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA  = 17'd65536;
   localparam logic [GAIN_W-1:0]  RST_INTEG_BAND    = 31'h7FFF_FFFF;
   localparam logic [GAIN_W-1:0]  RST_INTEG_LIMIT   = 31'd65536;
   localparam logic [GAIN_W-1:0]  RST_OUTPUT_CAP    = 31'd65536;
   localparam logic [GAIN_W-1:0]  RST_SAMPLE_PERIOD = 31'd655;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

   // datapath operations, one per sequencer step
   typedef enum logic [3:0] {
      OP_NOP,
      OP_FILT_A,
      OP_FILT_B,
      OP_FILT_SUM,
      OP_PROP,
      OP_DERIV,
      OP_INTEG_CHK,
      OP_DT,
      OP_INTEG_UPD
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
      logic   out_load;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pidfd_datapath.sv =====
// pid datapath: config registers, shared multiplier, state and result registers
`default_nettype none

module pidfd_datapath
   import pidfd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [GAIN_W-1:0]           csr_wdata,
   input  logic signed [DATA_W-1:0]    req_error_now,
   input  logic signed [DATA_W-1:0]    req_error_before,
   input  logic                        req_before_valid,
   input  logic signed [DATA_W-1:0]    req_deriv_raw,
   output logic signed [DATA_W-1:0]    rsp_drive,
   output logic signed [DATA_W-1:0]    rsp_p_part,
   output logic signed [DATA_W-1:0]    rsp_i_part,
   output logic signed [DATA_W-1:0]    rsp_d_part
);

   // keep bits [47:16] of a product, saturating to 32 bits
   function automatic logic signed [31:0] sat_q16(input logic signed [64:0] p);
      logic [17:0] hi;
      hi = p[64:47];
      if ((&hi) || !(|hi)) begin
         return p[47:16];
      end else if (p[64]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7FFF_FFFF;
      end
   endfunction

   function automatic logic signed [31:0] clamp_mag(input logic signed [33:0] x,
                                                    input logic [30:0] m);
      logic signed [33:0] mp;
      logic signed [33:0] mn;
      mp = {3'b000, m};
      mn = -mp;
      if (x > mp) begin
         return mp[31:0];
      end else if (x < mn) begin
         return mn[31:0];
      end else begin
         return x[31:0];
      end
   endfunction

   logic [GAIN_W-1:0]  kp_ff, ki_ff, kd_ff, band_ff, lim_ff, cap_ff, dt_ff;
   logic [ALPHA_W-1:0] alpha_ff;

   logic signed [DATA_W-1:0] e_ff, draw_ff;
   logic signed [DATA_W-1:0] fd_ff, integ_ff;
   logic signed [DATA_W-1:0] up_ff, ud_ff, kie_ff;
   logic                     en_ff;
   logic signed [64:0]       prod_ff, acc_ff;

   logic signed [DATA_W-1:0] drive_ff, p_part_ff, i_part_ff, d_part_ff;

   logic [ALPHA_W-1:0] a_eff, a_rest;
   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [64:0] product;
   logic signed [64:0] filt_sum;
   logic signed [33:0] uraw, isum, usum;
   logic [33:0]        absraw;
   logic signed [32:0] e_ext;
   logic [32:0]        abse;
   logic               saturating, crossed;
   logic signed [DATA_W-1:0] inc;
   logic signed [32:0] cap_pos, cap_neg, lim_pos, lim_neg;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= RST_PROP_GAIN;
         ki_ff    <= RST_INTEG_GAIN;
         kd_ff    <= RST_DERIV_GAIN;
         alpha_ff <= RST_FILTER_ALPHA;
         band_ff  <= RST_INTEG_BAND;
         lim_ff   <= RST_INTEG_LIMIT;
         cap_ff   <= RST_OUTPUT_CAP;
         dt_ff    <= RST_SAMPLE_PERIOD;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PROP_GAIN:     kp_ff    <= csr_wdata;
            REG_INTEG_GAIN:    ki_ff    <= csr_wdata;
            REG_DERIV_GAIN:    kd_ff    <= csr_wdata;
            REG_FILTER_ALPHA:  alpha_ff <= csr_wdata[ALPHA_W-1:0];
            REG_INTEG_BAND:    band_ff  <= csr_wdata;
            REG_INTEG_LIMIT:   lim_ff   <= csr_wdata;
            REG_OUTPUT_CAP:    cap_ff   <= csr_wdata;
            REG_SAMPLE_PERIOD: dt_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign a_eff  = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign a_rest = ALPHA_ONE - a_eff;

   // operand select for the one shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_FILT_A: begin
            mul_a = {16'b0, a_eff};
            mul_b = draw_ff;
         end
         OP_FILT_B: begin
            mul_a = {16'b0, a_rest};
            mul_b = fd_ff;
         end
         OP_FILT_SUM: begin
            mul_a = {2'b00, kp_ff};
            mul_b = e_ff;
         end
         OP_PROP: begin
            mul_a = {2'b00, kd_ff};
            mul_b = fd_ff;
         end
         OP_DERIV: begin
            mul_a = {2'b00, ki_ff};
            mul_b = e_ff;
         end
         OP_DT: begin
            mul_a = {2'b00, dt_ff};
            mul_b = kie_ff;
         end
         default: ;
      endcase
   end

   assign product  = mul_a * mul_b;
   assign filt_sum = acc_ff + prod_ff;

   assign uraw   = {{2{up_ff[31]}}, up_ff} + {{2{integ_ff[31]}}, integ_ff}
                 + {{2{ud_ff[31]}}, ud_ff};
   assign absraw = uraw[33] ? 34'(-uraw) : 34'(uraw);
   assign e_ext  = {e_ff[31], e_ff};
   assign abse   = e_ext[32] ? 33'(-e_ext) : 33'(e_ext);

   // output already pushing in the direction of the error
   assign saturating = (absraw >= {3'b000, cap_ff}) && (e_ff != '0)
                     && ((e_ff[31] && uraw[33])
                         || (!e_ff[31] && !uraw[33] && (uraw != '0)));

   assign inc  = sat_q16(prod_ff);
   assign isum = {{2{integ_ff[31]}}, integ_ff} + {{2{inc[31]}}, inc};
   assign usum = {{2{up_ff[31]}}, up_ff} + {{2{integ_ff[31]}}, integ_ff}
               + {{2{ud_ff[31]}}, ud_ff};

   assign crossed = req_before_valid && (req_error_now != '0) && (req_error_before != '0)
                  && (req_error_now[31] != req_error_before[31]);

   assign cap_pos = {2'b00, cap_ff};
   assign cap_neg = -cap_pos;
   assign lim_pos = {2'b00, lim_ff};
   assign lim_neg = -lim_pos;

   // controller state: filtered derivative and integrator
   always_ff @(posedge clock) begin
      if (reset) begin
         fd_ff    <= '0;
         integ_ff <= '0;
      end else begin
         if (cmd.load && crossed) begin
            integ_ff <= '0;
         end else if ((cmd.op == OP_INTEG_UPD) && en_ff) begin
            integ_ff <= clamp_mag(isum, lim_ff);
         end
         if (cmd.op == OP_FILT_SUM) begin
            fd_ff <= filt_sum[47:16];
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= product;
      if (cmd.load) begin
         e_ff    <= req_error_now;
         draw_ff <= req_deriv_raw;
      end
      case (cmd.op)
         OP_FILT_B:    acc_ff <= prod_ff;
         OP_PROP:      up_ff  <= sat_q16(prod_ff);
         OP_DERIV:     ud_ff  <= sat_q16(prod_ff);
         OP_INTEG_CHK: begin
            kie_ff <= sat_q16(prod_ff);
            en_ff  <= (abse <= {2'b00, band_ff}) && !saturating;
         end
         default: ;
      endcase
      if (cmd.out_load) begin
         drive_ff  <= clamp_mag(usum, cap_ff);
         p_part_ff <= up_ff;
         i_part_ff <= integ_ff;
         d_part_ff <= ud_ff;
      end
   end

   assign rsp_drive  = drive_ff;
   assign rsp_p_part = p_part_ff;
   assign rsp_i_part = i_part_ff;
   assign rsp_d_part = d_part_ff;

`include "pid_with_filtered_derivative_top_assert.svh"

   `PIDFD_ASSERT_NEXT(a_integ_in_limit, clock, reset, (cmd.op == OP_INTEG_UPD) && en_ff, ($signed({integ_ff[31], integ_ff}) <= lim_pos) && ($signed({integ_ff[31], integ_ff}) >= lim_neg))
   `PIDFD_ASSERT_NEXT(a_drive_in_cap, clock, reset, cmd.out_load, ($signed({drive_ff[31], drive_ff}) <= cap_pos) && ($signed({drive_ff[31], drive_ff}) >= cap_neg))

endmodule

`default_nettype wire

// ===== hw/rtl/pidfd_ctrl.sv =====
// pid sequencer: steps the datapath through one transaction and owns the handshakes
`default_nettype none

module pidfd_ctrl
   import pidfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_FILT_A    = 10'b00_0000_0010,
      ST_FILT_B    = 10'b00_0000_0100,
      ST_FILT_SUM  = 10'b00_0000_1000,
      ST_PROP      = 10'b00_0001_0000,
      ST_DERIV     = 10'b00_0010_0000,
      ST_INTEG_CHK = 10'b00_0100_0000,
      ST_DT        = 10'b00_1000_0000,
      ST_INTEG_UPD = 10'b01_0000_0000,
      ST_OUT       = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a new result
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.op       = OP_NOP;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_FILT_A;
            end
         end
         ST_FILT_A: begin
            cmd.op   = OP_FILT_A;
            state_in = ST_FILT_B;
         end
         ST_FILT_B: begin
            cmd.op   = OP_FILT_B;
            state_in = ST_FILT_SUM;
         end
         ST_FILT_SUM: begin
            cmd.op   = OP_FILT_SUM;
            state_in = ST_PROP;
         end
         ST_PROP: begin
            cmd.op   = OP_PROP;
            state_in = ST_DERIV;
         end
         ST_DERIV: begin
            cmd.op   = OP_DERIV;
            state_in = ST_INTEG_CHK;
         end
         ST_INTEG_CHK: begin
            cmd.op   = OP_INTEG_CHK;
            state_in = ST_DT;
         end
         ST_DT: begin
            cmd.op   = OP_DT;
            state_in = ST_INTEG_UPD;
         end
         ST_INTEG_UPD: begin
            cmd.op   = OP_INTEG_UPD;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`include "pid_with_filtered_derivative_top_assert.svh"

   `PIDFD_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall, state_ff == ST_FILT_A)
   `PIDFD_ASSERT_IMPLY(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT)
   `PIDFD_ASSERT_NEXT(a_out_to_idle, clock, reset, cmd.out_load, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

`default_nettype wire

// ===== hw/rtl/pid_with_filtered_derivative_top.sv =====
// pid controller with filtered derivative and conditional integration, top level
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | error_now, error_before, before_valid, deriv_raw
//  rsp     | out       | rsp_valid/rsp_stall  | drive, p_part, i_part, d_part
//  csr     | in        | csr_we               | csr_index, csr_wdata
//
//  a transaction runs from accept through the sequencer steps to rsp_valid; the next is taken only back in idle
//  the sequencer has nine steps around one shared 33x32 multiplier used six times
//  while a result waits in the output register the next transaction is already accepted
//  a stalled result holds the sequencer in its last step until the output register frees up
//  synchronous reset restores the register defaults and clears derivative and integrator
`default_nettype none

module pid_with_filtered_derivative_top
   import pidfd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_error_now,
   input  logic signed [DATA_W-1:0] req_error_before,
   input  logic                     req_before_valid,
   input  logic signed [DATA_W-1:0] req_deriv_raw,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_drive,
   output logic signed [DATA_W-1:0] rsp_p_part,
   output logic signed [DATA_W-1:0] rsp_i_part,
   output logic signed [DATA_W-1:0] rsp_d_part,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [GAIN_W-1:0]        csr_wdata
);

   cmd_type cmd;

   pidfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   pidfd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_error_now    (req_error_now),
      .req_error_before (req_error_before),
      .req_before_valid (req_before_valid),
      .req_deriv_raw    (req_deriv_raw),
      .rsp_drive        (rsp_drive),
      .rsp_p_part       (rsp_p_part),
      .rsp_i_part       (rsp_i_part),
      .rsp_d_part       (rsp_d_part)
   );

endmodule

`default_nettype wire
